>>> design/spsl_pkg.sv
package spsl_pkg;

  // sample and coefficient formats
  localparam int SAMPLE_BITS = 16;
  localparam int COEFF_BITS  = 24;
  localparam int ENV_FRAC    = 9;
  localparam int ENV_BITS    = SAMPLE_BITS + 1 + ENV_FRAC;
  localparam int MAG_BITS    = SAMPLE_BITS + 1;
  localparam int THR_BITS    = 15;
  localparam int THR_SHIFT   = SAMPLE_BITS + ENV_FRAC - 16;
  localparam int GAIN_FRAC   = 15;
  localparam int GAIN_BITS   = GAIN_FRAC + 1;
  localparam int CNT_BITS    = $clog2(GAIN_FRAC + 1);

  // shared multiplier, signed operands
  localparam int MUL_A_BITS = ENV_BITS + 1;
  localparam int MUL_B_BITS = COEFF_BITS + 2;
  localparam int PROD_BITS  = MUL_A_BITS + MUL_B_BITS;

  localparam logic [GAIN_BITS-1:0] GAIN_ONE = GAIN_BITS'(1) << GAIN_FRAC;
  // largest peak level: two full-scale magnitudes in envelope units
  localparam logic [ENV_BITS-1:0]  ENV_MAX  = ENV_BITS'(1) << (SAMPLE_BITS + ENV_FRAC);

  // configuration registers
  localparam int CFG_IDX_BITS = 2;
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_ATTACK    = 2'd0,
    CFG_RELEASE   = 2'd1,
    CFG_THRESHOLD = 2'd2
  } cfg_idx_e;

  localparam logic [COEFF_BITS-1:0] ATTACK_RST    = COEFF_BITS'(6590036);
  localparam logic [COEFF_BITS-1:0] RELEASE_RST   = COEFF_BITS'(1674);
  localparam logic [THR_BITS-1:0]   THRESHOLD_RST = THR_BITS'(29491);

  // microcode
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_MUL_KEEP,
    OP_ACC_DIFF,
    OP_MUL_ATK,
    OP_ENV_UPD,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_GAIN,
    OP_MUL_L,
    OP_MUL_R,
    OP_OUT
  } op_e;

  typedef enum logic [2:0] {
    SEQ_NEXT,
    SEQ_HOLD_IN,
    SEQ_SKIP_NOLIM,
    SEQ_LOOP_DIV,
    SEQ_HOLD_OUT,
    SEQ_JUMP
  } seq_e;

  localparam int STEP_BITS = 4;

  typedef struct packed {
    op_e                  op;
    seq_e                 seq;
    logic [STEP_BITS-1:0] target;
  } ucode_t;

  localparam logic [STEP_BITS-1:0] STEP_LOAD     = 4'd0;
  localparam logic [STEP_BITS-1:0] STEP_MUL_KEEP = 4'd1;
  localparam logic [STEP_BITS-1:0] STEP_ACC_DIFF = 4'd2;
  localparam logic [STEP_BITS-1:0] STEP_MUL_ATK  = 4'd3;
  localparam logic [STEP_BITS-1:0] STEP_ENV_UPD  = 4'd4;
  localparam logic [STEP_BITS-1:0] STEP_DIV_INIT = 4'd5;
  localparam logic [STEP_BITS-1:0] STEP_DIV_STEP = 4'd6;
  localparam logic [STEP_BITS-1:0] STEP_GAIN     = 4'd7;
  localparam logic [STEP_BITS-1:0] STEP_MUL_L    = 4'd8;
  localparam logic [STEP_BITS-1:0] STEP_MUL_R    = 4'd9;
  localparam logic [STEP_BITS-1:0] STEP_OUT      = 4'd10;

  // program rom
  function automatic ucode_t ucode_rom(logic [STEP_BITS-1:0] step);
    ucode_t w;
    w = '{op: OP_NOP, seq: SEQ_JUMP, target: STEP_LOAD};
    case (step)
      STEP_LOAD:     w = '{op: OP_LOAD,     seq: SEQ_HOLD_IN,    target: STEP_LOAD};
      STEP_MUL_KEEP: w = '{op: OP_MUL_KEEP, seq: SEQ_NEXT,       target: STEP_LOAD};
      STEP_ACC_DIFF: w = '{op: OP_ACC_DIFF, seq: SEQ_NEXT,       target: STEP_LOAD};
      STEP_MUL_ATK:  w = '{op: OP_MUL_ATK,  seq: SEQ_NEXT,       target: STEP_LOAD};
      STEP_ENV_UPD:  w = '{op: OP_ENV_UPD,  seq: SEQ_NEXT,       target: STEP_LOAD};
      STEP_DIV_INIT: w = '{op: OP_DIV_INIT, seq: SEQ_SKIP_NOLIM, target: STEP_MUL_L};
      STEP_DIV_STEP: w = '{op: OP_DIV_STEP, seq: SEQ_LOOP_DIV,   target: STEP_LOAD};
      STEP_GAIN:     w = '{op: OP_GAIN,     seq: SEQ_NEXT,       target: STEP_LOAD};
      STEP_MUL_L:    w = '{op: OP_MUL_L,    seq: SEQ_NEXT,       target: STEP_LOAD};
      STEP_MUL_R:    w = '{op: OP_MUL_R,    seq: SEQ_NEXT,       target: STEP_LOAD};
      STEP_OUT:      w = '{op: OP_OUT,      seq: SEQ_HOLD_OUT,   target: STEP_LOAD};
      default:       w = '{op: OP_NOP,      seq: SEQ_JUMP,       target: STEP_LOAD};
    endcase
    return w;
  endfunction

endpackage

>>> design/stereo_peak_soft_limiter_core.sv
// flow: the load, envelope update and output steps run for every item; when the
//   envelope is above threshold, 15 restoring divide steps and the gain step are added
// items: one in flight; the microcode program and the one-bit-per-cycle divider loop
//   run before the next is taken; the input is taken again while a result waits
// reset: async active low; envelope cleared to zero, config registers to their defaults,
//   sequencer back at the load step, no result pending
module stereo_peak_soft_limiter_core
  import spsl_pkg::*;
(
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write port
  input  logic                           cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]        cfg_idx_i,
  input  logic [COEFF_BITS-1:0]          cfg_data_i,
  // input item channel
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0]  left_sample_i,
  input  logic signed [SAMPLE_BITS-1:0]  right_sample_i,
  // result item channel
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [SAMPLE_BITS-1:0]  left_out_o,
  output logic signed [SAMPLE_BITS-1:0]  right_out_o,
  output logic [GAIN_BITS-1:0]           gain_applied_o
);

  // config registers
  logic [COEFF_BITS-1:0] attack_q;
  logic [COEFF_BITS-1:0] release_q;
  logic [THR_BITS-1:0]   threshold_q;

  // sequencer and kept state
  logic [STEP_BITS-1:0]  step_q, step_d;
  logic                  out_valid_q;
  logic [ENV_BITS-1:0]   env_q;

  // datapath registers
  logic signed [SAMPLE_BITS-1:0] samp_l_q, samp_r_q;
  logic [ENV_BITS-1:0]           peak_q;
  logic [ENV_BITS-1:0]           acc_q;
  logic [ENV_BITS-1:0]           diff_q;
  logic signed [PROD_BITS-1:0]   prod_q;
  logic [ENV_BITS-1:0]           rem_q;
  logic [GAIN_FRAC-1:0]          quo_q;
  logic [CNT_BITS-1:0]           cnt_q;
  logic [GAIN_BITS-1:0]          gain_q;
  logic signed [SAMPLE_BITS-1:0] left_res_q;
  logic signed [SAMPLE_BITS-1:0] left_out_q, right_out_q;
  logic [GAIN_BITS-1:0]          gain_out_q;

  ucode_t uw;
  logic   fire;
  logic   out_free;
  logic   limited;

  logic [ENV_BITS-1:0]           thr_env;
  logic [COEFF_BITS:0]           keep;
  logic [MAG_BITS-1:0]           mag_l, mag_r, mag_sum;
  logic signed [MUL_A_BITS-1:0]  mul_a;
  logic signed [MUL_B_BITS-1:0]  mul_b;
  logic signed [PROD_BITS-1:0]   prod_d;
  logic [ENV_BITS:0]             rem_dbl;
  logic [ENV_BITS-1:0]           prod_scaled;

  assign uw       = ucode_rom(step_q);
  assign out_free = !out_valid_q || out_ready_i;
  assign thr_env  = ENV_BITS'(threshold_q) << THR_SHIFT;
  assign limited  = env_q > thr_env;
  assign keep     = ((COEFF_BITS + 1)'(1) << COEFF_BITS) - (COEFF_BITS + 1)'(release_q);

  // magnitudes; full-scale negative keeps its 2^(n-1) value in the wider word
  assign mag_l   = left_sample_i[SAMPLE_BITS-1]
                 ? MAG_BITS'(0) - MAG_BITS'($unsigned(left_sample_i)) - {1'b1, SAMPLE_BITS'(0)}
                 : MAG_BITS'($unsigned(left_sample_i));
  assign mag_r   = right_sample_i[SAMPLE_BITS-1]
                 ? MAG_BITS'(0) - MAG_BITS'($unsigned(right_sample_i)) - {1'b1, SAMPLE_BITS'(0)}
                 : MAG_BITS'($unsigned(right_sample_i));
  assign mag_sum = mag_l + mag_r;

  // sequencer next step and the gate for waiting steps
  always_comb begin
    fire   = 1'b1;
    step_d = step_q + STEP_BITS'(1);
    case (uw.seq)
      SEQ_NEXT: begin
        step_d = step_q + STEP_BITS'(1);
      end
      SEQ_HOLD_IN: begin
        fire   = in_valid_i;
        step_d = in_valid_i ? step_q + STEP_BITS'(1) : step_q;
      end
      SEQ_SKIP_NOLIM: begin
        step_d = limited ? step_q + STEP_BITS'(1) : uw.target;
      end
      SEQ_LOOP_DIV: begin
        step_d = (cnt_q != CNT_BITS'(1)) ? step_q : step_q + STEP_BITS'(1);
      end
      SEQ_HOLD_OUT: begin
        fire   = out_free;
        step_d = out_free ? uw.target : step_q;
      end
      SEQ_JUMP: begin
        step_d = uw.target;
      end
      default: begin
        step_d = STEP_LOAD;
      end
    endcase
  end

  assign in_ready_o = (uw.op == OP_LOAD);

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (uw.op)
      OP_MUL_KEEP: begin
        mul_a = MUL_A_BITS'($signed({1'b0, env_q}));
        mul_b = MUL_B_BITS'($signed({1'b0, keep}));
      end
      OP_MUL_ATK: begin
        mul_a = MUL_A_BITS'($signed({1'b0, diff_q}));
        mul_b = MUL_B_BITS'($signed({2'b00, attack_q}));
      end
      OP_MUL_L: begin
        mul_a = MUL_A_BITS'(samp_l_q);
        mul_b = MUL_B_BITS'($signed({1'b0, gain_q}));
      end
      OP_MUL_R: begin
        mul_a = MUL_A_BITS'(samp_r_q);
        mul_b = MUL_B_BITS'($signed({1'b0, gain_q}));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d      = mul_a * mul_b;
  assign prod_scaled = prod_q[COEFF_BITS+ENV_BITS-1:COEFF_BITS];
  assign rem_dbl     = {rem_q, 1'b0};

  // control state, config and envelope
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= STEP_LOAD;
      out_valid_q <= 1'b0;
      env_q       <= '0;
      attack_q    <= ATTACK_RST;
      release_q   <= RELEASE_RST;
      threshold_q <= THRESHOLD_RST;
    end else begin
      step_q <= step_d;
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (uw.op == OP_OUT && fire) begin
        out_valid_q <= 1'b1;
      end
      if (uw.op == OP_ENV_UPD) begin
        env_q <= acc_q + prod_scaled;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ATTACK:    attack_q    <= cfg_data_i;
          CFG_RELEASE:   release_q   <= cfg_data_i;
          CFG_THRESHOLD: threshold_q <= cfg_data_i[THR_BITS-1:0];
          default:       ;
        endcase
      end
    end
  end

  // datapath, driven by the control word
  always_ff @(posedge clk_i) begin
    if (fire) begin
      case (uw.op)
        OP_LOAD: begin
          samp_l_q <= left_sample_i;
          samp_r_q <= right_sample_i;
          peak_q   <= {mag_sum, ENV_FRAC'(0)};
        end
        OP_MUL_KEEP, OP_MUL_ATK, OP_MUL_L: begin
          prod_q <= prod_d;
        end
        OP_ACC_DIFF: begin
          acc_q  <= prod_scaled;
          diff_q <= (peak_q > env_q) ? peak_q - env_q : '0;
        end
        OP_DIV_INIT: begin
          rem_q  <= thr_env;
          quo_q  <= '0;
          cnt_q  <= CNT_BITS'(GAIN_FRAC);
          gain_q <= GAIN_ONE;
        end
        OP_DIV_STEP: begin
          // restoring step, one quotient bit
          if (rem_dbl >= {1'b0, env_q}) begin
            rem_q <= ENV_BITS'(rem_dbl - {1'b0, env_q});
            quo_q <= {quo_q[GAIN_FRAC-2:0], 1'b1};
          end else begin
            rem_q <= rem_dbl[ENV_BITS-1:0];
            quo_q <= {quo_q[GAIN_FRAC-2:0], 1'b0};
          end
          cnt_q <= cnt_q - CNT_BITS'(1);
        end
        OP_GAIN: begin
          gain_q <= {1'b0, quo_q};
        end
        OP_MUL_R: begin
          left_res_q <= prod_q[GAIN_FRAC+SAMPLE_BITS-1:GAIN_FRAC];
          prod_q     <= prod_d;
        end
        OP_OUT: begin
          left_out_q  <= left_res_q;
          right_out_q <= prod_q[GAIN_FRAC+SAMPLE_BITS-1:GAIN_FRAC];
          gain_out_q  <= gain_q;
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign left_out_o     = left_out_q;
  assign right_out_o    = right_out_q;
  assign gain_applied_o = gain_out_q;

  // one item in flight: after an accept the input stays closed
  a_single_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted twice in a row");

  // divider loop never runs with an exhausted count
  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q == STEP_DIV_STEP |-> cnt_q != '0)
    else $error("divide step with zero count");

  // envelope cannot pass the largest peak level
  a_env_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    env_q <= ENV_MAX)
    else $error("envelope above maximum peak");

  // a result is loaded only into a free output slot
  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q == STEP_OUT && out_valid_q && !out_ready_i |=> step_q == STEP_OUT)
    else $error("result overwrote a pending item");

  // gain never above unity
  a_gain_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> gain_out_q <= GAIN_ONE)
    else $error("gain above unity");

endmodule
